### hw/rtl/ubxfe_pkg.sv
// Shared types and constants for the binary GNSS frame encoder.
`timescale 1ns / 1ps
package ubxfe_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 1024;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_LEN_ERR = 2'd1,
      STATUS_NO_FRAME = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_DATA,
      CMD_ERR_LEN,
      CMD_ERR_NOFRAME
   } cmd_op_type;

   // byte0 is the class on a start, the data byte on a payload transaction
   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [15:0] len;
      logic        close;
   } cmd_type;

endpackage

### hw/rtl/ubx_frame_encoder.sv
// Top level of the binary GNSS command frame encoder.
`timescale 1ns / 1ps
// Usage:
//  req_* carries one transaction: a start (class, id, payload length) or one
//  payload byte. rsp_* delivers the frame one byte per transaction, with
//  frame_end on CK_B, last_of_run on the final byte of each input and a
//  status code for an oversize length or a payload byte with no open frame.
//  A start produces 6 bytes (8 if the length is zero), a payload byte 1
//  (3 when it closes the frame), an error 1.
//  With the queue and output register empty, an accepted input goes first
//  into the command queue, then into the output register. Throughput: one
//  output byte per cycle while rsp_ready is high, set by the serialiser
//  step counter; input is taken at one per cycle while the command queue
//  has room (QUEUE_DEPTH entries), so payload streams at one byte per cycle.
//  Reset: no frame open, sums zero, queue and output register empty.
//  A stall on rsp_ready holds the output byte; the queue absorbs inputs
//  until it fills, then req_ready falls.
module ubx_frame_encoder
   import ubxfe_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_msg_class,
   input  logic [7:0]  req_msg_id,
   input  logic [15:0] req_payload_len,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_last_of_run,
   output logic [1:0]  rsp_status
);

   logic    q_full, q_push, q_pop, q_valid;
   cmd_type push_cmd, head_cmd;

   ubxfe_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_msg_class  (req_msg_class),
      .req_msg_id     (req_msg_id),
      .req_payload_len(req_payload_len),
      .req_data_byte  (req_data_byte),
      .q_full_i       (q_full),
      .q_push_o       (q_push),
      .q_cmd_o        (push_cmd)
   );

   ubxfe_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_i    (q_push),
      .push_cmd_i(push_cmd),
      .full_o    (q_full),
      .pop_i     (q_pop),
      .valid_o   (q_valid),
      .head_cmd_o(head_cmd)
   );

   ubxfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid_i      (q_valid),
      .q_cmd_i        (head_cmd),
      .q_pop_o        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_status     (rsp_status)
   );

endmodule

### hw/rtl/ubxfe_front.sv
// Front end: accepts transactions, tracks the open frame and issues commands.
`timescale 1ns / 1ps
module ubxfe_front
   import ubxfe_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_msg_class,
   input  logic [7:0]  req_msg_id,
   input  logic [15:0] req_payload_len,
   input  logic [7:0]  req_data_byte,
   input  logic        q_full_i,
   output logic        q_push_o,
   output cmd_type     q_cmd_o
);

   logic        frame_open_ff, frame_open_in;
   logic [15:0] bytes_left_ff, bytes_left_in;

   assign req_ready = !q_full_i;
   assign q_push_o  = req_valid && !q_full_i;

   always_comb begin
      q_cmd_o.op    = CMD_ERR_NOFRAME;
      q_cmd_o.byte0 = req_data_byte;
      q_cmd_o.byte1 = req_msg_id;
      q_cmd_o.len   = req_payload_len;
      q_cmd_o.close = 1'b0;
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      if (req_kind == KIND_START) begin
         if (req_payload_len > 16'(MAX_PAYLOAD)) begin
            q_cmd_o.op = CMD_ERR_LEN;
         end else begin
            // a start abandons any open frame
            q_cmd_o.op    = CMD_START;
            q_cmd_o.byte0 = req_msg_class;
            q_cmd_o.close = (req_payload_len == 16'd0);
            frame_open_in = (req_payload_len != 16'd0);
            bytes_left_in = req_payload_len;
         end
      end else if (frame_open_ff && bytes_left_ff != 16'd0) begin
         q_cmd_o.op    = CMD_DATA;
         q_cmd_o.close = (bytes_left_ff == 16'd1);
         frame_open_in = (bytes_left_ff != 16'd1);
         bytes_left_in = bytes_left_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 16'd0;
      end else if (q_push_o) begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   a_open_tracks_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (bytes_left_ff != 16'd0))
      else $error("frame_open out of step with bytes_left");

   a_close_on_last: assert property (@(posedge clock) disable iff (reset)
      (q_push_o && q_cmd_o.op == CMD_DATA && q_cmd_o.close) |=> !frame_open_ff)
      else $error("frame still open after closing byte");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full_i |-> !q_push_o)
      else $error("command issued into full queue");

endmodule

### hw/rtl/ubxfe_queue.sv
// Short command queue between front end and serialiser.
`timescale 1ns / 1ps
module ubxfe_queue
   import ubxfe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_i,
   input  cmd_type push_cmd_i,
   output logic    full_o,
   input  logic    pop_i,
   output logic    valid_o,
   output cmd_type head_cmd_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full_o     = (count_ff == CNT_W'(DEPTH));
   assign valid_o    = (count_ff != '0);
   assign head_cmd_o = entry_ff[rd_ptr_ff];
   assign do_push    = push_i && !full_o;
   assign do_pop     = pop_i && valid_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd_i;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> valid_o)
      else $error("pop from empty queue");

endmodule

### hw/rtl/ubxfe_back.sv
// Back end: serialises commands into bytes and keeps the Fletcher sums.
`timescale 1ns / 1ps
module ubxfe_back
   import ubxfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid_i,
   input  cmd_type    q_cmd_i,
   output logic       q_pop_o,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_last_of_run,
   output logic [1:0] rsp_status
);

   logic [2:0] step_ff, step_in;
   logic [7:0] sum_a_ff, sum_a_in;
   logic [7:0] sum_b_ff, sum_b_in;
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       frame_end_ff, last_ff;
   status_type status_ff;

   logic       load, fire;
   logic [7:0] byte_val;
   logic       summed, clear_sums, is_end, is_final;
   status_type status_val;
   logic [7:0] sum_a_add;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign fire    = load && q_valid_i;
   assign q_pop_o = fire && is_final;

   // byte sequence per command, indexed by step
   always_comb begin
      byte_val   = 8'd0;
      summed     = 1'b0;
      clear_sums = 1'b0;
      is_end     = 1'b0;
      is_final   = 1'b1;
      status_val = STATUS_OK;
      case (q_cmd_i.op)
         CMD_START: begin
            is_final = q_cmd_i.close ? (step_ff == 3'd7) : (step_ff == 3'd5);
            case (step_ff)
               3'd0: begin
                  byte_val   = SYNC_FIRST;
                  clear_sums = 1'b1;
               end
               3'd1: byte_val = SYNC_SECOND;
               3'd2: begin
                  byte_val = q_cmd_i.byte0;
                  summed   = 1'b1;
               end
               3'd3: begin
                  byte_val = q_cmd_i.byte1;
                  summed   = 1'b1;
               end
               3'd4: begin
                  byte_val = q_cmd_i.len[7:0];
                  summed   = 1'b1;
               end
               3'd5: begin
                  byte_val = q_cmd_i.len[15:8];
                  summed   = 1'b1;
               end
               3'd6: byte_val = sum_a_ff;
               default: begin
                  byte_val = sum_b_ff;
                  is_end   = 1'b1;
               end
            endcase
         end
         CMD_DATA: begin
            is_final = q_cmd_i.close ? (step_ff == 3'd2) : (step_ff == 3'd0);
            case (step_ff)
               3'd0: begin
                  byte_val = q_cmd_i.byte0;
                  summed   = 1'b1;
               end
               3'd1: byte_val = sum_a_ff;
               default: begin
                  byte_val = sum_b_ff;
                  is_end   = 1'b1;
               end
            endcase
         end
         CMD_ERR_LEN: status_val = STATUS_LEN_ERR;
         default:     status_val = STATUS_NO_FRAME;
      endcase
   end

   assign sum_a_add = sum_a_ff + byte_val;

   always_comb begin
      step_in  = step_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      if (fire) begin
         step_in = is_final ? 3'd0 : step_ff + 3'd1;
         if (clear_sums) begin
            sum_a_in = 8'd0;
            sum_b_in = 8'd0;
         end else if (summed) begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_ff + sum_a_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= q_valid_i;
         end
         step_ff  <= step_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff  <= byte_val;
         frame_end_ff <= is_end;
         last_ff      <= is_final;
         status_ff    <= status_val;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_frame_end   = frame_end_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_status      = status_ff;

   a_step_short_cmds: assert property (@(posedge clock) disable iff (reset)
      (q_valid_i && q_cmd_i.op != CMD_START) |-> (step_ff <= 3'd2))
      else $error("step beyond data command length");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (q_valid_i && (q_cmd_i.op == CMD_ERR_LEN || q_cmd_i.op == CMD_ERR_NOFRAME))
         |-> (step_ff == 3'd0))
      else $error("error command mid-sequence");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_end_ff) |-> last_ff)
      else $error("frame end not last byte of transaction");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      !q_valid_i |-> (step_ff == 3'd0))
      else $error("sequence step left over with queue empty");

endmodule

### test/testbench.sv
// Self-checking testbench for the GNSS frame encoder: random frames, idling phases, byte checks.
`timescale 1ns / 1ps
module testbench;
   import ubxfe_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int TIMEOUT_NS = 5_000_000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      logic        kind;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_len;
      logic [7:0]  data_byte;
   } stim_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       last_of_run;
      status_type status;
   } wire_byte_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idling_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_START;
   logic [7:0]  req_msg_class = 8'h00;
   logic [7:0]  req_msg_id = 8'h00;
   logic [15:0] req_payload_len = 16'h0000;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic        rsp_last_of_run;
   logic [1:0]  rsp_status;

   stim_type      pending_items[$];
   wire_byte_type expected_bytes[$];
   int            items_queued = 0;
   int            items_accepted = 0;
   int            mismatch_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   logic          req_taken = 1'b0;

   // predictor state
   logic [7:0]    ck_a = 8'h00;
   logic [7:0]    ck_b = 8'h00;
   logic [15:0]   bytes_left = 16'h0000;
   logic          frame_open = 1'b0;
   wire_byte_type held_byte;
   logic          have_held = 1'b0;

   ubx_frame_encoder #(
      .MAX_PAYLOAD(MAX_PAYLOAD_DEFAULT),
      .QUEUE_DEPTH(QUEUE_DEPTH_DEFAULT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_msg_class(req_msg_class),
      .req_msg_id(req_msg_id),
      .req_payload_len(req_payload_len),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_frame_end(rsp_frame_end),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
   endtask

   // each byte is held back one step so the last of a burst can be tagged
   task automatic stage_byte(input logic [7:0] value, input logic fin, input status_type st);
      if (have_held)
         expected_bytes.push_back(held_byte);
      held_byte.out_byte = value;
      held_byte.frame_end = fin;
      held_byte.last_of_run = 1'b0;
      held_byte.status = st;
      have_held = 1'b1;
   endtask

   task automatic stage_summed(input logic [7:0] value);
      ck_a = ck_a + value;
      ck_b = ck_b + ck_a;
      stage_byte(value, 1'b0, STATUS_OK);
   endtask

   task automatic stage_checksum();
      stage_byte(ck_a, 1'b0, STATUS_OK);
      stage_byte(ck_b, 1'b1, STATUS_OK);
      frame_open = 1'b0;
      bytes_left = 16'h0000;
   endtask

   task automatic encode_transaction(input stim_type s);
      if (s.kind == KIND_START) begin
         if (s.payload_len > MAX_PAYLOAD_DEFAULT) begin
            // oversize length: state untouched, an open frame stays open
            stage_byte(8'h00, 1'b0, STATUS_LEN_ERR);
         end else begin
            ck_a = 8'h00;
            ck_b = 8'h00;
            stage_byte(SYNC_FIRST, 1'b0, STATUS_OK);
            stage_byte(SYNC_SECOND, 1'b0, STATUS_OK);
            stage_summed(s.msg_class);
            stage_summed(s.msg_id);
            stage_summed(s.payload_len[7:0]);
            stage_summed(s.payload_len[15:8]);
            if (s.payload_len == 16'h0000) begin
               stage_checksum();
            end else begin
               frame_open = 1'b1;
               bytes_left = s.payload_len;
            end
         end
      end else if (!frame_open || bytes_left == 16'h0000) begin
         stage_byte(8'h00, 1'b0, STATUS_NO_FRAME);
      end else begin
         stage_summed(s.data_byte);
         bytes_left = bytes_left - 16'd1;
         if (bytes_left == 16'h0000)
            stage_checksum();
      end
      held_byte.last_of_run = 1'b1;
      expected_bytes.push_back(held_byte);
      have_held = 1'b0;
   endtask

   always @(negedge clock) begin : drive_requests
      stim_type s;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               s = pending_items.pop_front();
               req_valid <= 1'b1;
               req_kind <= s.kind;
               req_msg_class <= s.msg_class;
               req_msg_id <= s.msg_id;
               req_payload_len <= s.payload_len;
               req_data_byte <= s.data_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_bytes
      wire_byte_type want;
      stim_type s;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected byte", int'(rsp_out_byte), 0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", int'(rsp_out_byte), int'(want.out_byte));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", int'(rsp_frame_end), int'(want.frame_end));
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", int'(rsp_last_of_run),
                                  int'(want.last_of_run));
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
            end
         end
         if (req_valid && req_ready) begin
            s.kind = req_kind;
            s.msg_class = req_msg_class;
            s.msg_id = req_msg_id;
            s.payload_len = req_payload_len;
            s.data_byte = req_data_byte;
            encode_transaction(s);
            items_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   task automatic queue_item(input logic kind, input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input logic [7:0] data);
      stim_type s;
      s.kind = kind;
      s.msg_class = cls;
      s.msg_id = id;
      s.payload_len = len;
      s.data_byte = data;
      pending_items.push_back(s);
      items_queued++;
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || expected_bytes.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_idling(input idling_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 72;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 72;
         end
         default: begin
            send_idle_pct = 18;
            recv_stall_pct = 18;
         end
      endcase
   endtask

   // mostly well-formed frames with random content, some cut short, plus noise
   task automatic random_phase(input idling_type mode, input int target);
      int made;
      int pick;
      int len;
      int body;
      set_idling(mode);
      made = 0;
      while (made < target) begin
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            queue_item(KIND_START, 8'($urandom), 8'($urandom),
                       16'($urandom_range(65535, MAX_PAYLOAD_DEFAULT + 1)), 8'($urandom));
            made++;
         end else if (pick < 14) begin
            queue_item(KIND_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                       8'($urandom));
            made++;
         end else begin
            pick = $urandom_range(99, 0);
            if (pick < 65)
               len = $urandom_range(6, 0);
            else if (pick < 92)
               len = $urandom_range(40, 7);
            else
               len = $urandom_range(MAX_PAYLOAD_DEFAULT, 41);
            body = len;
            // long frames are always abandoned; short ones now and then
            if (len > 0 && (len > 40 || $urandom_range(9, 0) == 0))
               body = $urandom_range((len > 20) ? 20 : len - 1, 0);
            queue_item(KIND_START, 8'($urandom), 8'($urandom), 16'(len), 8'($urandom));
            repeat (body)
               queue_item(KIND_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom));
            made += 1 + body;
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      // payload with nothing open
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF);
      // zero-length frame closes within the header burst
      queue_item(KIND_START, 8'h00, 8'h00, 16'h0000, 8'h00);
      // oversize lengths, just past the limit and at the top
      queue_item(KIND_START, 8'hFF, 8'hFF, 16'd1025, 8'hFF);
      queue_item(KIND_START, 8'hAA, 8'h55, 16'hFFFF, 8'h00);
      queue_item(KIND_START, 8'h06, 8'h01, 16'd3, 8'h00);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00);
      queue_item(KIND_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hA5);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h3C);
      queue_item(KIND_START, 8'hFF, 8'h00, 16'd1, 8'h00);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h80);
      // maximum length, oversize start mid-frame, then abandoned by a new start
      queue_item(KIND_START, 8'h55, 8'hAA, 16'(MAX_PAYLOAD_DEFAULT), 8'h00);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h01);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFE);
      queue_item(KIND_START, 8'h01, 8'h02, 16'd2000, 8'h00);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h7F);
      queue_item(KIND_START, 8'h0A, 8'h04, 16'd2, 8'h00);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h10);
      queue_item(KIND_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hEF);
      wait_drained();

      random_phase(IDLE_NONE, 90);
      random_phase(IDLE_SENDER, 90);
      random_phase(IDLE_RECEIVER, 90);
      random_phase(IDLE_BOTH, 90);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch("bytes still expected", expected_bytes.size(), 0);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("testbench: FAIL");
      $finish;
   end

endmodule

### sim.f
hw/rtl/ubxfe_pkg.sv
hw/rtl/ubxfe_front.sv
hw/rtl/ubxfe_queue.sv
hw/rtl/ubxfe_back.sv
hw/rtl/ubx_frame_encoder.sv
test/testbench.sv
